>>> src/pfbo_pkg.sv
`default_nettype none
package pfbo_pkg;

   localparam logic OP_OR   = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam int PAGE_ROWS = 8;

   typedef struct packed {
      logic capture;  // take the input item into the working registers
      logic rd_lo;    // read the byte at the first page
      logic rd_hi;    // read the byte at the next page
      logic wr_lo;    // write back the first page byte
      logic wr_hi;    // write back the next page byte
      logic clr_wr;   // zero one entry of the clearing sweep
      logic load_rsp; // load the result register
   } pfbo_cmd_type;

   typedef struct packed {
      logic op_read;
      logic wr_in_range;
      logic spill_en;
      logic clr_last;
      logic rsp_free;
   } pfbo_status_type;

endpackage
`default_nettype wire

>>> src/pfbo_dpath.sv
`default_nettype none
module pfbo_dpath import pfbo_pkg::*; #(
   parameter int COLUMNS = 128,
   parameter int ROWS    = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire pfbo_cmd_type    cmd,
   output pfbo_status_type      status,
   input  wire logic            req_op,
   input  wire logic [7:0]      req_column,
   input  wire logic [7:0]      req_pixel_row,
   input  wire logic [2:0]      req_read_page,
   input  wire logic [7:0]      req_pixels,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [7:0]           rsp_read_byte
);

   localparam int PAGES = (ROWS + PAGE_ROWS - 1) / PAGE_ROWS;
   localparam int DEPTH = COLUMNS * PAGES;
   localparam int AW    = $clog2(DEPTH);

   logic [7:0]    frame_mem [DEPTH];
   logic [7:0]    rdata_ff;

   logic          op_ff;
   logic [7:0]    col_ff;
   logic [7:0]    row_ff;
   logic [4:0]    page_ff;
   logic [7:0]    pix_ff;

   logic [AW-1:0] clr_cnt_ff;
   logic [AW-1:0] clr_cnt_in;

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [7:0]    rsp_byte_ff;

   logic          col_ok;
   logic          rd_in_range;
   logic [AW-1:0] addr_lo;
   logic [AW-1:0] addr_hi;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          wr_en;
   logic [15:0]   shifted;

   // range checks on the captured item
   assign col_ok      = {1'b0, col_ff} < 9'(COLUMNS);
   assign rd_in_range = col_ok && ({1'b0, page_ff} < 6'(PAGES));
   assign addr_lo     = AW'(32'(page_ff) * COLUMNS + 32'(col_ff));
   assign addr_hi     = AW'(32'(addr_lo) + COLUMNS);
   assign shifted     = {8'b0, pix_ff} << row_ff[2:0];

   assign status.op_read     = op_ff == OP_READ;
   assign status.wr_in_range = col_ok && ({1'b0, row_ff} < 9'(ROWS));
   assign status.spill_en    = (row_ff[2:0] != 3'd0) &&
                               ((6'(page_ff) + 6'd1) < 6'(PAGES));
   assign status.clr_last    = clr_cnt_ff == AW'(DEPTH - 1);
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign rd_addr = cmd.rd_hi ? addr_hi : addr_lo;

   always_comb begin
      wr_en   = cmd.clr_wr || cmd.wr_lo || cmd.wr_hi;
      wr_addr = addr_lo;
      wr_data = rdata_ff | shifted[7:0];
      if (cmd.clr_wr) begin
         wr_addr = clr_cnt_ff;
         wr_data = 8'd0;
      end else if (cmd.wr_hi) begin
         wr_addr = addr_hi;
         wr_data = rdata_ff | shifted[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_lo || cmd.rd_hi) begin
         rdata_ff <= frame_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         col_ff  <= req_column;
         row_ff  <= req_pixel_row;
         pix_ff  <= req_pixels;
         page_ff <= (req_op == OP_READ) ? {2'b00, req_read_page} : req_pixel_row[7:3];
      end
      if (cmd.load_rsp) begin
         rsp_byte_ff <= rd_in_range ? rdata_ff : 8'd0;
      end
   end

   always_comb begin
      clr_cnt_in = cmd.clr_wr ? clr_cnt_ff + AW'(1) : clr_cnt_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_byte_ff;

endmodule
`default_nettype wire

>>> src/pfbo_ctrl.sv
`default_nettype none
module pfbo_ctrl import pfbo_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire pfbo_status_type status,
   output pfbo_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_WLO,
      ST_WHI,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = state_ff != ST_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (status.op_read) begin
               cmd.rd_lo = 1'b1;
               state_in  = ST_RESP;
            end else if (status.wr_in_range) begin
               cmd.rd_lo = 1'b1;
               state_in  = ST_WLO;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WLO: begin
            // write back the first page, and fetch the next one when bits spill into it
            cmd.wr_lo = 1'b1;
            if (status.spill_en) begin
               cmd.rd_hi = 1'b1;
               state_in  = ST_WHI;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WHI: begin
            cmd.wr_hi = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_RESP: begin
            // hold until the result register is free
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> src/page_framebuffer_byte_or.sv
// A write passes ISSUE (read first page), WLO (write it back, read the next page if bits
// spill) and WHI (write the next page back); with no spill it ends after WLO, and off screen
// after ISSUE. A read passes ISSUE and RESP, which waits while a held result stalls the
// result side. The frame memory has one read and one write port; a new request is taken only
// in IDLE. A synchronous reset starts a clearing sweep of all COLUMNS*ceil(ROWS/8) entries,
// one entry a cycle, during which req_stall stays high; the result channel resets empty.
`default_nettype none
module page_framebuffer_byte_or import pfbo_pkg::*; #(
   parameter int COLUMNS = 128,
   parameter int ROWS    = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_op,
   input  wire logic [7:0] req_column,
   input  wire logic [7:0] req_pixel_row,
   input  wire logic [2:0] req_read_page,
   input  wire logic [7:0] req_pixels,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_byte
);

   pfbo_cmd_type    cmd;
   pfbo_status_type status;

   pfbo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pfbo_dpath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_op        (req_op),
      .req_column    (req_column),
      .req_pixel_row (req_pixel_row),
      .req_read_page (req_read_page),
      .req_pixels    (req_pixels),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_byte (rsp_read_byte)
   );

endmodule
`default_nettype wire
